// ===== hw/rtl/tcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Types, character codes and helper functions shared by the console formatter.
// ----------------------------------------------------------------------------
package tcc_pkg;

   localparam int BCD_DIGITS = 10;
   localparam int BCD_WIDTH  = 4 * BCD_DIGITS;
   localparam int NUM_WIDTH  = 32;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS = NUM_WIDTH / BITS_PER_STEP;

   localparam logic [1:0] OP_CHAR = 2'd0;
   localparam logic [1:0] OP_DEC  = 2'd1;
   localparam logic [1:0] OP_HEX  = 2'd2;

   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_CR      = 8'd13;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] TAB_MASK     = ~8'd7;
   localparam logic [7:0] COLOR_RESET  = 8'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } tcc_state_type;

   typedef enum logic [1:0] {
      MODE_CHAR,
      MODE_DEC,
      MODE_HEX
   } tcc_mode_type;

   typedef struct packed {
      logic        written;
      logic [10:0] address;
      logic [7:0]  char_code;
      logic [7:0]  color;
      logic [6:0]  column;
      logic [4:0]  line;
   } tcc_result_type;

   function automatic logic [7:0] hex_char(input logic [3:0] digit);
      logic [7:0] c;
      case (digit)
         4'h0: c = 8'h30;
         4'h1: c = 8'h31;
         4'h2: c = 8'h32;
         4'h3: c = 8'h33;
         4'h4: c = 8'h34;
         4'h5: c = 8'h35;
         4'h6: c = 8'h36;
         4'h7: c = 8'h37;
         4'h8: c = 8'h38;
         4'h9: c = 8'h39;
         4'hA: c = 8'h41;
         4'hB: c = 8'h42;
         4'hC: c = 8'h43;
         4'hD: c = 8'h44;
         4'hE: c = 8'h45;
         default: c = 8'h46;
      endcase
      return c;
   endfunction

   // index of the highest nonzero digit, zero when all digits are zero
   function automatic logic [3:0] lead_index(input logic [BCD_WIDTH-1:0] digits);
      logic [3:0] idx;
      idx = 4'd0;
      for (int d = 1; d < BCD_DIGITS; d++) begin
         if (digits[d*4 +: 4] != 4'd0) begin
            idx = 4'(d);
         end
      end
      return idx;
   endfunction

endpackage

// ===== hw/rtl/text_console_cursor_formatter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_formatter_top
// Text console formatter: characters, signed decimal and hex numbers are
// turned into a stream of cell writes with cursor tracking and wrap.
//
//   channel  direction  handshake          payload
//   req_     in         valid / stall      op, char_code, number
//   rsp_     out        valid / stall      cell fields, cursor, last
//   csr_     in         write enable       text color
//
// One beat per emitted character, at most one per cycle. A character is a
// single beat; hex takes 3 to 10 beats; decimal first passes through the BCD
// shift unit (32 bits, 4 per cycle), then takes 1 to 11 beats. Input stalls
// from accept until the final beat is registered.
// Reset is synchronous; rsp_stall holds the output register and the sequencer.
// ----------------------------------------------------------------------------
module text_console_cursor_formatter_top
   import tcc_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_char_code,
   input  logic [31:0] req_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_cell_written,
   output logic [10:0] rsp_cell_address,
   output logic [7:0]  rsp_cell_char,
   output logic [7:0]  rsp_cell_color,
   output logic [6:0]  rsp_cursor_column,
   output logic [4:0]  rsp_cursor_line,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   tcc_state_type        state_ff, state_in;
   tcc_mode_type         mode_ff, mode_in;
   logic [7:0]           char_ff, char_in;
   logic [1:0]           pre_cnt_ff, pre_cnt_in;
   logic [3:0]           idx_ff, idx_in;
   logic [BCD_WIDTH-1:0] digits_ff, digits_in;
   logic [7:0]           color_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   tcc_result_type       rsp_data_ff;
   logic                 rsp_last_ff;

   logic                 accept;
   logic                 emit_go;
   logic                 emit_last;
   logic [7:0]           emit_char;
   logic                 conv_start;
   logic                 conv_done;
   logic [BCD_WIDTH-1:0] conv_digits;
   logic [NUM_WIDTH-1:0] magnitude;
   tcc_result_type       cur_result;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign magnitude = req_number[31] ? (32'd0 - req_number) : req_number;
   assign conv_start = accept && (req_op == OP_DEC);

   tcc_bcd_conv u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (conv_start),
      .value  (magnitude),
      .done   (conv_done),
      .digits (conv_digits)
   );

   tcc_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .clock     (clock),
      .reset     (reset),
      .commit    (emit_go),
      .char_code (emit_char),
      .color     (color_ff),
      .result    (cur_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op) inside
                  OP_DEC:              state_in = ST_CONVERT;
                  OP_CHAR, OP_HEX:     state_in = ST_EMIT;
                  default:             state_in = ST_IDLE;
               endcase
            end
         end
         ST_CONVERT: begin
            if (conv_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go && emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // character selection
   always_comb begin
      emit_last = 1'b0;
      emit_char = hex_char(digits_ff[idx_ff*4 +: 4]);
      unique case (mode_ff)
         MODE_CHAR: begin
            emit_char = char_ff;
            emit_last = 1'b1;
         end
         MODE_DEC: begin
            if (pre_cnt_ff != 2'd0) emit_char = CHAR_MINUS;
            emit_last = (pre_cnt_ff == 2'd0) && (idx_ff == 4'd0);
         end
         MODE_HEX: begin
            if (pre_cnt_ff == 2'd2)      emit_char = CHAR_ZERO;
            else if (pre_cnt_ff == 2'd1) emit_char = CHAR_X;
            emit_last = (pre_cnt_ff == 2'd0) && (idx_ff == 4'd0);
         end
         default: emit_last = 1'b1;
      endcase
   end

   // sequencer datapath
   always_comb begin
      mode_in    = mode_ff;
      char_in    = char_ff;
      pre_cnt_in = pre_cnt_ff;
      idx_in     = idx_ff;
      digits_in  = digits_ff;
      if (accept) begin
         char_in = req_char_code;
         case (req_op)
            OP_DEC: begin
               mode_in    = MODE_DEC;
               pre_cnt_in = {1'b0, req_number[31]};
            end
            OP_HEX: begin
               mode_in    = MODE_HEX;
               pre_cnt_in = 2'd2;
               digits_in  = {{(BCD_WIDTH-NUM_WIDTH){1'b0}}, req_number};
               idx_in     = lead_index({{(BCD_WIDTH-NUM_WIDTH){1'b0}}, req_number});
            end
            default: begin
               mode_in = MODE_CHAR;
            end
         endcase
      end else if (state_ff == ST_CONVERT && conv_done) begin
         digits_in = conv_digits;
         idx_in    = lead_index(conv_digits);
      end else if (emit_go) begin
         if (pre_cnt_ff != 2'd0) pre_cnt_in = pre_cnt_ff - 2'd1;
         else if (idx_ff != 4'd0) idx_in = idx_ff - 4'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_go)         rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_CHAR;
         pre_cnt_ff   <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         color_ff     <= COLOR_RESET;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         pre_cnt_ff   <= pre_cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) color_ff <= csr_write_data;
      end
      char_ff   <= char_in;
      digits_ff <= digits_in;
      if (emit_go) begin
         rsp_data_ff <= cur_result;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_written  = rsp_data_ff.written;
   assign rsp_cell_address  = rsp_data_ff.address;
   assign rsp_cell_char     = rsp_data_ff.char_code;
   assign rsp_cell_color    = rsp_data_ff.color;
   assign rsp_cursor_column = rsp_data_ff.column;
   assign rsp_cursor_line   = rsp_data_ff.line;
   assign rsp_last          = rsp_last_ff;

   a_done_in_convert: assert property (@(posedge clock) disable iff (reset)
      conv_done |-> state_ff == ST_CONVERT)
      else $error("converter finished outside conversion");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      emit_go && emit_last |=> state_ff == ST_IDLE && rsp_valid && rsp_last)
      else $error("final beat did not close the item");

   a_no_beat_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && !rsp_stall |=> !rsp_valid)
      else $error("beat produced while idle");

   a_digit_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> idx_ff < 4'(BCD_DIGITS))
      else $error("digit index out of range");

endmodule

// ===== hw/rtl/tcc_bcd_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_bcd_conv
// Iterative binary to BCD converter, shift-and-add-3, four bits per cycle.
// ----------------------------------------------------------------------------
module tcc_bcd_conv
   import tcc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] value,
   output logic                 done,
   output logic [BCD_WIDTH-1:0] digits
);

   logic [BCD_WIDTH-1:0] bcd_ff, bcd_in;
   logic [NUM_WIDTH-1:0] shift_ff, shift_in;
   logic [2:0]           count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   always_comb begin
      logic [BCD_WIDTH-1:0] b;
      logic [NUM_WIDTH-1:0] s;
      b = bcd_ff;
      s = shift_ff;
      for (int step = 0; step < BITS_PER_STEP; step++) begin
         for (int d = 0; d < BCD_DIGITS; d++) begin
            if (b[d*4 +: 4] >= 4'd5) begin
               b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
            end
         end
         b = {b[BCD_WIDTH-2:0], s[NUM_WIDTH-1]};
         s = {s[NUM_WIDTH-2:0], 1'b0};
      end

      bcd_in   = bcd_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         bcd_in   = '0;
         shift_in = value;
         count_in = 3'(CONV_STEPS - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         bcd_in   = b;
         shift_in = s;
         count_in = count_ff - 3'd1;
         if (count_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      bcd_ff   <= bcd_in;
      shift_ff <= shift_in;
   end

   assign done   = done_ff;
   assign digits = bcd_ff;

endmodule

// ===== hw/rtl/tcc_cursor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_cursor
// Cursor column and row; decodes one character into a cell write or a control move.
// ----------------------------------------------------------------------------
module tcc_cursor
   import tcc_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           commit,
   input  logic [7:0]     char_code,
   input  logic [7:0]     color,
   output tcc_result_type result
);

   logic [6:0] column_ff, column_in;
   logic [4:0] row_ff, row_in;

   always_comb begin
      logic [7:0]  col;
      logic [5:0]  row;
      logic [11:0] addr;
      col  = {1'b0, column_ff};
      row  = {1'b0, row_ff};
      addr = 12'(row_ff) * 12'(COLUMNS) + 12'(column_ff);
      result = '0;
      unique case (char_code)
         CHAR_NEWLINE: begin
            col = 8'd0;
            row = row + 6'd1;
         end
         CHAR_CR: begin
            col = 8'd0;
         end
         CHAR_TAB: begin
            col = (col + 8'd8) & TAB_MASK;
         end
         default: begin
            result.written   = 1'b1;
            result.address   = addr[10:0];
            result.char_code = char_code;
            result.color     = color;
            col = col + 8'd1;
         end
      endcase
      if (col >= 8'(COLUMNS)) begin
         col = 8'd0;
         row = row + 6'd1;
      end
      if (row >= 6'(ROWS)) begin
         row = 6'd0;
      end
      column_in     = commit ? col[6:0] : column_ff;
      row_in        = commit ? row[4:0] : row_ff;
      result.column = col[6:0];
      result.line   = row[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   a_column_range: assert property (@(posedge clock) disable iff (reset)
      32'(column_ff) < COLUMNS)
      else $error("cursor column out of range");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      32'(row_ff) < ROWS)
      else $error("cursor row out of range");

   a_hold_cursor: assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(column_ff) && $stable(row_ff))
      else $error("cursor moved without a character");

endmodule
